// File: hdl/deqs_pkg.sv
// shared types and codes for the double-ended queue with search
`default_nettype none
package deqs_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned KIND_W        = 3;
   localparam int unsigned STATUS_W      = 3;
   localparam int unsigned DEFAULT_DEPTH = 16;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] popped_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH
   } state_type;

endpackage
`default_nettype wire

// File: hdl/deqs_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module deqs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/double_ended_queue_with_search_core.sv
// double-ended queue of signed words in a ring ram, with linear membership search
//
// usage: present an operation on req_data and raise start; it is taken at a
// clock edge where start is high and busy is low. each operation gives exactly
// one result on rsp_data, marked by rsp_valid for a single cycle; the receiver
// cannot stall and must take it in that cycle.
// operations: push front, pop front, push back, pop back, search. a push on a
// full queue returns full, a pop on an empty queue returns empty, and neither
// changes the contents. unused kind codes return ok and change nothing.
// result timing: pushes, refused pops and searches of an empty queue give their
// result in the cycle after the transfer; a pop first does one ram read.
// a search reads one entry per cycle from the ram read port and stops at the
// first match or after the last occupied entry. busy is high while a pop or
// search is in flight, so the next operation can be taken in the cycle its
// predecessor's result is shown. reset empties the queue at once (front index
// and count cleared); the ram contents are not cleared, since only occupied
// entries are ever read.
`default_nettype none
module double_ended_queue_with_search_core #(
   parameter int unsigned DEPTH = deqs_pkg::DEFAULT_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire deqs_pkg::req_type req_data,
   output logic                  rsp_valid,
   output deqs_pkg::rsp_type     rsp_data
);
   import deqs_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned OCC_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = IDX_W + 1;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   count_ff, count_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               is_pop;
   logic               is_search;
   logic               search_done;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [DATA_W-1:0]  rd_data;

   // position of the entry at a given offset from the front, wrapped once
   function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                  input logic [OCC_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   deqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_pop    = (req_data.kind == KIND_POP_FRONT) || (req_data.kind == KIND_POP_BACK);
   assign is_search = (req_data.kind == KIND_SEARCH);
   // rd_data holds the entry at offset count_ff - 1
   assign search_done = (rd_data == key_ff) || (count_ff == occ_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_pop && (occ_ff != '0)) begin
               state_in = ST_POP;
            end else if (accept && is_search && (occ_ff != '0)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (search_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath, ram control and result
   always_comb begin
      front_in     = front_ff;
      occ_in       = occ_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      wr_data      = req_data.value;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: STATUS_OK, popped_value: '0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (occ_ff == OCC_W'(DEPTH)) begin
                        rsp_in.status = STATUS_FULL;
                     end else if (req_data.kind == KIND_PUSH_FRONT) begin
                        front_in = (front_ff == '0) ? IDX_W'(DEPTH - 1)
                                                    : front_ff - IDX_W'(1);
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        occ_in   = occ_ff + OCC_W'(1);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ring_addr(front_ff, occ_ff);
                        occ_in  = occ_ff + OCC_W'(1);
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else if (req_data.kind == KIND_POP_FRONT) begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        front_in = ring_addr(front_ff, OCC_W'(1));
                        occ_in   = occ_ff - OCC_W'(1);
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = ring_addr(front_ff, occ_ff - OCC_W'(1));
                        occ_in  = occ_ff - OCC_W'(1);
                     end
                  end
                  KIND_SEARCH: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        count_in = OCC_W'(1);
                        key_in   = req_data.value;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_valid_in        = 1'b1;
            rsp_in.popped_value = rd_data;
         end
         ST_SEARCH: begin
            if (rd_data == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_FOUND;
            end else if (count_ff == occ_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_NOT_FOUND;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ring_addr(front_ff, count_ff);
               count_in = count_ff + OCC_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (rsp_valid_ff && (rsp_ff.status == STATUS_OK)))
      else $error("pop read did not produce a result");

   a_search_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((count_ff <= occ_ff) && (count_ff != '0)))
      else $error("search offset out of range");

   a_no_result_while_waiting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !rsp_valid_ff)
      else $error("result shown before pop data returned");

   a_zero_unless_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_OK)) |-> (rsp_ff.popped_value == '0))
      else $error("popped value set on refused or search result");

endmodule
`default_nettype wire

// File: verif/double_ended_queue_with_search_core_tb.sv
// self-checking testbench for the double-ended queue with search core
`default_nettype none
module double_ended_queue_with_search_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deqs_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;

   // kind codes the block ignores
   localparam logic [KIND_W-1:0] KIND_SPARE_0 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_1 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_2 = 3'd7;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      int                       reps;
      bit                       typed;
      rsp_type                  exp;
   } op_row_type;

   typedef struct {
      rsp_type rsp;
      int      item_no;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   double_ended_queue_with_search_core #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the ring store
   logic signed [DATA_W-1:0] shadow_store [DEPTH];
   int                       shadow_front = 0;
   int                       shadow_count = 0;

   pending_type pending_results [$];
   int          error_count = 0;
   int          accepted_count = 0;
   bit          use_typed = 1'b0;
   rsp_type     typed_rsp = '0;
   int          idle_pct = 0;

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic rsp_type apply_deque_op(input req_type op);
      rsp_type r;
      int      pos;
      r.status       = STATUS_OK;
      r.popped_value = '0;
      case (op.kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else if (op.kind == KIND_PUSH_FRONT) begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_store[shadow_front] = op.value;
               shadow_count++;
            end else begin
               shadow_store[(shadow_front + shadow_count) % DEPTH] = op.value;
               shadow_count++;
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else if (op.kind == KIND_POP_FRONT) begin
               r.popped_value = shadow_store[shadow_front];
               shadow_front = (shadow_front + 1) % DEPTH;
               shadow_count--;
            end else begin
               pos = (shadow_front + shadow_count - 1) % DEPTH;
               r.popped_value = shadow_store[pos];
               shadow_count--;
            end
         end
         KIND_SEARCH: begin
            r.status = STATUS_NOT_FOUND;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_store[(shadow_front + i) % DEPTH] == op.value) begin
                  r.status = STATUS_FOUND;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // transfer tracking and result checking
   always @(posedge clock) begin
      pending_type p;
      rsp_type     predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               flag_error($sformatf("unexpected result status %0d value %0d",
                  rsp_data.status, rsp_data.popped_value));
            end else begin
               p = pending_results.pop_front();
               if (rsp_data.status !== p.rsp.status)
                  flag_error($sformatf("item %0d status %0d, expected %0d",
                     p.item_no, rsp_data.status, p.rsp.status));
               if (rsp_data.popped_value !== p.rsp.popped_value)
                  flag_error($sformatf("item %0d popped_value %0d, expected %0d",
                     p.item_no, rsp_data.popped_value, p.rsp.popped_value));
            end
         end
         if (start && !busy) begin
            predicted = apply_deque_op(req_data);
            p.rsp     = use_typed ? typed_rsp : predicted;
            p.item_no = accepted_count;
            pending_results.push_back(p);
            accepted_count++;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value,
                          input bit typed, input rsp_type exp);
      req_type op;
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_data <= {KIND_W'($urandom), DATA_W'($urandom)};
         @(negedge clock);
      end
      op.kind   = kind;
      op.value  = value;
      use_typed = typed;
      typed_rsp = exp;
      start    <= 1'b1;
      req_data <= op;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      use_typed = 1'b0;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3:    return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   op_row_type directed_ops [25] = '{
      '{KIND_POP_FRONT,  32'sd0,          1,  1'b1, '{STATUS_EMPTY, 32'sd0}},
      '{KIND_POP_BACK,   32'sd0,          1,  1'b1, '{STATUS_EMPTY, 32'sd0}},
      '{KIND_SEARCH,     32'sd0,          1,  1'b1, '{STATUS_NOT_FOUND, 32'sd0}},
      '{KIND_SPARE_0,    -32'sd1,         1,  1'b1, '{STATUS_OK, 32'sd0}},
      '{KIND_SPARE_1,    32'sh5a5a5a5a,   1,  1'b1, '{STATUS_OK, 32'sd0}},
      '{KIND_SPARE_2,    -32'sd1,         1,  1'b1, '{STATUS_OK, 32'sd0}},
      '{KIND_PUSH_FRONT, 32'sh7fffffff,   1,  1'b1, '{STATUS_OK, 32'sd0}},
      '{KIND_PUSH_BACK,  32'sh80000000,   1,  1'b1, '{STATUS_OK, 32'sd0}},
      '{KIND_SEARCH,     32'sh80000000,   1,  1'b1, '{STATUS_FOUND, 32'sd0}},
      '{KIND_SEARCH,     32'sh7fffffff,   1,  1'b1, '{STATUS_FOUND, 32'sd0}},
      '{KIND_SEARCH,     -32'sd1,         1,  1'b1, '{STATUS_NOT_FOUND, 32'sd0}},
      '{KIND_POP_BACK,   -32'sd1,         1,  1'b1, '{STATUS_OK, 32'sh80000000}},
      '{KIND_POP_FRONT,  -32'sd1,         1,  1'b1, '{STATUS_OK, 32'sh7fffffff}},
      '{KIND_POP_FRONT,  32'sd0,          1,  1'b1, '{STATUS_EMPTY, 32'sd0}},
      // fill to capacity, values count up per repetition
      '{KIND_PUSH_BACK,  32'sd100,        16, 1'b0, '0},
      '{KIND_PUSH_FRONT, -32'sd5,         1,  1'b1, '{STATUS_FULL, 32'sd0}},
      '{KIND_PUSH_BACK,  -32'sd5,         1,  1'b1, '{STATUS_FULL, 32'sd0}},
      // rear entry must be searched too
      '{KIND_SEARCH,     32'sd115,        1,  1'b0, '0},
      '{KIND_SEARCH,     32'sd100,        1,  1'b0, '0},
      '{KIND_SEARCH,     -32'sd5,         1,  1'b0, '0},
      '{KIND_POP_BACK,   32'sd0,          1,  1'b0, '0},
      '{KIND_PUSH_FRONT, -32'sd1,         1,  1'b0, '0},
      '{KIND_POP_FRONT,  32'sd0,          1,  1'b0, '0},
      '{KIND_POP_FRONT,  32'sd0,          15, 1'b0, '0},
      '{KIND_POP_BACK,   32'sd0,          1,  1'b1, '{STATUS_EMPTY, 32'sd0}}
   };

   initial begin
      int                       phase_idle [4];
      int                       push_bias;
      int                       burst_left;
      int                       r;
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      phase_idle = '{0, 63, 0, 26};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_pct = 26;
      foreach (directed_ops[i]) begin
         for (int k = 0; k < directed_ops[i].reps; k++)
            send_op(directed_ops[i].kind, directed_ops[i].value + k,
                    directed_ops[i].typed, directed_ops[i].exp);
      end
      drain_results();

      push_bias  = 50;
      burst_left = 0;
      foreach (phase_idle[ph]) begin
         idle_pct = phase_idle[ph];
         for (int n = 0; n < 224; n++) begin
            if (burst_left == 0) begin
               case ($urandom_range(2))
                  0:       push_bias = 25;
                  1:       push_bias = 50;
                  default: push_bias = 75;
               endcase
               burst_left = $urandom_range(40, 15);
            end
            burst_left--;
            r = $urandom_range(99);
            if (r < 4) begin
               kind  = KIND_W'(KIND_SPARE_0 + $urandom_range(2));
               value = $urandom;
            end else if (r < 24) begin
               kind = KIND_SEARCH;
               if (shadow_count > 0 && $urandom_range(1))
                  value = shadow_store[(shadow_front + $urandom_range(shadow_count - 1))
                                       % DEPTH];
               else
                  value = pick_value();
            end else if ($urandom_range(99) < push_bias) begin
               kind  = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
               value = pick_value();
            end else begin
               kind  = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
               value = $urandom;
            end
            send_op(kind, value, 1'b0, '0);
         end
         // hold off until the block has answered everything
         drain_results();
      end

      for (int w = 0; w < 5000 && pending_results.size() != 0; w++) @(negedge clock);
      repeat (DEPTH + 4) @(negedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
